>>> rtl/assert_macros.svh
// Assertion macros for the escape sequence parser.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define AESP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check an implication in the following cycle.
`define AESP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/aesp_pkg.sv
// Shared types and constants of the escape sequence parser.
// No dependencies; imported by every module of the block.
`default_nettype none
package aesp_pkg;

	localparam int DATA_W     = 8;
	localparam int COUNT_W    = 13;
	localparam int INDEX_W    = 12;
	localparam int STATE_W    = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W     = 2;
	localparam int QCNT_W     = 3;
	localparam int OUT_TDATA_W = 48;

	localparam logic [COUNT_W-1:0] BODY_MAX = 13'd4096;

	localparam logic [7:0] BYTE_ESC    = 8'h1B;
	localparam logic [7:0] BYTE_BEL    = 8'h07;
	localparam logic [7:0] BYTE_CSI    = 8'h5B;
	localparam logic [7:0] BYTE_OSC    = 8'h5D;
	localparam logic [7:0] BYTE_DCS    = 8'h50;
	localparam logic [7:0] BYTE_SOS    = 8'h58;
	localparam logic [7:0] BYTE_PM     = 8'h5E;
	localparam logic [7:0] BYTE_APC    = 8'h5F;
	localparam logic [7:0] BYTE_BSLASH = 8'h5C;

	localparam logic [1:0] EV_TEXT  = 2'd0;
	localparam logic [1:0] EV_SEQ   = 2'd1;
	localparam logic [1:0] EV_END   = 2'd2;
	localparam logic [1:0] EV_ABORT = 2'd3;

	localparam logic [STATE_W-1:0] ST_GROUND = 3'd0;
	localparam logic [STATE_W-1:0] ST_ESC    = 3'd1;
	localparam logic [STATE_W-1:0] ST_CSI    = 3'd2;
	localparam logic [STATE_W-1:0] ST_STR    = 3'd3;
	localparam logic [STATE_W-1:0] ST_STRESC = 3'd4;
	localparam logic [STATE_W-1:0] ST_NF     = 3'd5;

	localparam logic REG_CAPTURE  = 1'b0;
	localparam logic REG_RESUBMIT = 1'b1;

	typedef struct packed {
		logic [DATA_W-1:0] rx_byte;
		logic              is_esc;
		logic              is_bel;
		logic              is_csi;
		logic              is_str;
		logic              is_bslash;
		logic              r30_7e;
		logic              r20_2f;
		logic              r40_7e;
		logic              r20_3f;
		logic              ge_20;
	} cls_t;

	typedef struct packed {
		logic capture_enable;
		logic resubmit_on_abort;
	} cfg_t;

	typedef struct packed {
		logic [INDEX_W-1:0] captured_index;
		logic [DATA_W-1:0]  captured_byte;
		logic               captured_valid;
		logic               string_ok;
		logic [COUNT_W-1:0] body_length;
		logic [DATA_W-1:0]  seq_introducer;
		logic [1:0]         event_res;
	} res_t;

endpackage
`default_nettype wire

>>> rtl/aesp_front.sv
// Front end: accepts raw bytes, classifies them and hands them to the queue.
// Depends on aesp_pkg.
`default_nettype none
module aesp_front
	import aesp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [DATA_W-1:0] in_byte,
	output logic                   q_push,
	input  wire logic              q_ready,
	output cls_t                   q_data
);

	logic vld_s1;
	cls_t cls_s1;
	cls_t cls_c;

	always_comb begin
		cls_c.rx_byte   = in_byte;
		cls_c.is_esc    = (in_byte == BYTE_ESC);
		cls_c.is_bel    = (in_byte == BYTE_BEL);
		cls_c.is_csi    = (in_byte == BYTE_CSI);
		cls_c.is_str    = (in_byte == BYTE_OSC) || (in_byte == BYTE_DCS) ||
			(in_byte == BYTE_SOS) || (in_byte == BYTE_PM) || (in_byte == BYTE_APC);
		cls_c.is_bslash = (in_byte == BYTE_BSLASH);
		cls_c.r30_7e    = (in_byte >= 8'h30) && (in_byte <= 8'h7E);
		cls_c.r20_2f    = (in_byte >= 8'h20) && (in_byte <= 8'h2F);
		cls_c.r40_7e    = (in_byte >= 8'h40) && (in_byte <= 8'h7E);
		cls_c.r20_3f    = (in_byte >= 8'h20) && (in_byte <= 8'h3F);
		cls_c.ge_20     = (in_byte >= 8'h20);
	end

	assign in_ready = !vld_s1 || q_ready;
	assign q_push   = vld_s1;
	assign q_data   = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cls_s1 <= cls_c;
		end
	end

endmodule
`default_nettype wire

>>> rtl/aesp_queue.sv
// Short queue of classified words between front and back end.
// Depends on aesp_pkg.
`default_nettype none
module aesp_queue
	import aesp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic      push_ready,
	input  cls_t      push_data,
	output logic      pop_valid,
	input  wire logic pop,
	output cls_t      pop_data
);

	cls_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + QCNT_W'(1);
				2'b01: count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

>>> rtl/aesp_back.sv
// Back end: sequence state machine, body counting and the output register.
// Depends on aesp_pkg.
`default_nettype none
module aesp_back
	import aesp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  cfg_t      cfg,
	input  wire logic q_valid,
	output logic      q_pop,
	input  cls_t      q_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output res_t      out_res
);

	logic [STATE_W-1:0] state_q;
	logic [COUNT_W-1:0] count_q;
	logic               bad_q;
	logic [DATA_W-1:0]  intro_q;
	logic               out_valid_q;
	res_t               res_q;

	logic [STATE_W-1:0] state_d;
	logic [COUNT_W-1:0] count_d;
	logic               bad_d;
	logic [DATA_W-1:0]  intro_d;
	logic [1:0]         ev;
	logic               cap_v;
	logic               room;
	logic               abort;
	res_t               res_d;

	assign room = !bad_q && (count_q < BODY_MAX);

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		bad_d   = bad_q;
		intro_d = intro_q;
		ev      = EV_SEQ;
		cap_v   = 1'b0;
		abort   = 1'b0;
		case (state_q)
			ST_ESC: begin
				if (q_data.is_csi || q_data.is_str) begin
					state_d = q_data.is_csi ? ST_CSI : ST_STR;
					count_d = '0;
					bad_d   = 1'b0;
					intro_d = q_data.rx_byte;
				end else if (q_data.r30_7e) begin
					state_d = ST_GROUND;
					intro_d = q_data.rx_byte;
					ev      = EV_END;
				end else if (q_data.r20_2f) begin
					state_d = ST_NF;
					count_d = '0;
					bad_d   = 1'b0;
					intro_d = q_data.rx_byte;
				end else begin
					abort = 1'b1;
				end
			end
			ST_CSI, ST_NF: begin
				if ((state_q == ST_CSI) ? q_data.r40_7e : q_data.r30_7e) begin
					if (room) begin
						cap_v   = 1'b1;
						count_d = count_q + COUNT_W'(1);
						state_d = ST_GROUND;
						ev      = EV_END;
					end else begin
						abort = 1'b1;
					end
				end else if (((state_q == ST_CSI) ? q_data.r20_3f : q_data.r20_2f) && room) begin
					cap_v   = 1'b1;
					count_d = count_q + COUNT_W'(1);
				end else begin
					abort = 1'b1;
				end
			end
			ST_STR: begin
				if (q_data.is_bel) begin
					state_d = ST_GROUND;
					ev      = EV_END;
				end else if (q_data.is_esc) begin
					state_d = ST_STRESC;
				end else if (q_data.ge_20 && room) begin
					cap_v   = 1'b1;
					count_d = count_q + COUNT_W'(1);
				end else begin
					abort = 1'b1;
				end
			end
			ST_STRESC: begin
				if (q_data.is_bslash) begin
					state_d = ST_GROUND;
					ev      = EV_END;
				end else begin
					abort = 1'b1;
				end
			end
			default: begin
				if (q_data.is_esc) begin
					state_d = ST_ESC;
					count_d = '0;
					bad_d   = 1'b0;
					intro_d = '0;
				end else begin
					state_d = ST_GROUND;
					ev      = EV_TEXT;
				end
			end
		endcase
		if (abort) begin
			state_d = ST_GROUND;
			bad_d   = 1'b1;
			ev      = EV_ABORT;
			if (cfg.resubmit_on_abort) begin
				if (q_data.is_esc) begin
					state_d = ST_ESC;
					count_d = '0;
					bad_d   = 1'b0;
					intro_d = '0;
					ev      = EV_SEQ;
				end else begin
					ev = EV_TEXT;
				end
			end
		end
	end

	always_comb begin
		res_d.event_res      = ev;
		res_d.seq_introducer = intro_d;
		res_d.body_length    = count_d;
		res_d.string_ok      = cfg.capture_enable && !bad_d && (intro_d != '0);
		res_d.captured_valid = cap_v && cfg.capture_enable;
		res_d.captured_byte  = res_d.captured_valid ? q_data.rx_byte : '0;
		res_d.captured_index = res_d.captured_valid ? count_q[INDEX_W-1:0] : '0;
	end

	assign q_pop     = q_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_GROUND;
			count_q     <= '0;
			bad_q       <= 1'b0;
			intro_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				state_q <= state_d;
				count_q <= count_d;
				bad_q   <= bad_d;
				intro_q <= intro_d;
			end
			if (q_pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= res_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/ansi_escape_sequence_parser.sv
// Terminal escape sequence parser: APB registers, front end, queue, back end.
// Depends on aesp_pkg, aesp_front, aesp_queue, aesp_back, assert_macros.svh.
//
// One raw byte enters per word on the s_axis channel; one result word leaves
// on m_axis for every byte. A result tells text, inside sequence, end or
// abort, with the introducer, body count and any captured body byte.
// An accepted byte passes the front register, the queue and the output register
// before it shows on m_axis. Throughput is one byte per cycle while m_axis_tready
// is high, set by the state update in the back end; the front end and the four-word
// queue keep accepting while a result waits in the output register.
// When m_axis_tready is low, the output word holds, the queue fills and
// s_axis_tready drops once the queue and the front register are full.
// Reset clears the parser to ground with an empty body, the queue and both
// registers (capture_enable at 0x0, resubmit_on_abort at 0x4) to zero.
// Write registers only while no byte is in flight.
`default_nettype none
`include "assert_macros.svh"
module ansi_escape_sequence_parser
	import aesp_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [2:0]             paddr,
	input  wire logic [31:0]            pwdata,
	output logic      [31:0]            prdata,
	output logic                        pready,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// [7:0] rx_byte
	input  wire logic [7:0]             s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// [1:0] event_res, [9:2] seq_introducer, [22:10] body_length, [23] string_ok,
	// [24] captured_valid, [32:25] captured_byte, [44:33] captured_index, rest zero
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

	cfg_t cfg_q;
	logic q_push;
	logic q_ready;
	cls_t q_in;
	logic q_valid;
	logic q_pop;
	cls_t q_out;
	res_t res;
	logic out_cap;
	logic out_abort;
	logic out_seq_or_end;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_CAPTURE:  cfg_q.capture_enable    <= pwdata[0];
				REG_RESUBMIT: cfg_q.resubmit_on_abort <= pwdata[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_CAPTURE:  prdata = {31'd0, cfg_q.capture_enable};
			REG_RESUBMIT: prdata = {31'd0, cfg_q.resubmit_on_abort};
			default: prdata = '0;
		endcase
	end

	aesp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.q_push   (q_push),
		.q_ready  (q_ready),
		.q_data   (q_in)
	);

	aesp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_ready (q_ready),
		.push_data  (q_in),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_data   (q_out)
	);

	aesp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_data    (q_out),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {3'd0, res};

	assign out_cap        = m_axis_tvalid && res.captured_valid;
	assign out_abort      = m_axis_tvalid && (res.event_res == EV_ABORT);
	assign out_seq_or_end = (res.event_res == EV_SEQ) || (res.event_res == EV_END);

	`AESP_ASSERT_IMP(a_cap_needs_enable, out_cap, cfg_q.capture_enable, "capture is off")
	`AESP_ASSERT_IMP(a_no_abort_resubmit, out_abort, !cfg_q.resubmit_on_abort, "abort reported")
	`AESP_ASSERT_IMP(a_cap_in_sequence, out_cap, out_seq_or_end, "capture outside a sequence")
	`AESP_ASSERT_NXT(a_pop_fills_output, q_pop, m_axis_tvalid, "popped word lost before output")

endmodule
`default_nettype wire

>>> dv/ansi_escape_sequence_parser_tb.sv
// Testbench for the terminal escape sequence parser: drives bytes on the input
// stream, predicts each result word and checks it on the output stream.
// Depends on aesp_pkg and ansi_escape_sequence_parser; register writes go over APB.
module ansi_escape_sequence_parser_tb;
	import aesp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [7:0] byte_q_t [$];

	localparam logic [2:0] ADDR_CAPTURE  = {REG_CAPTURE, 2'b00};
	localparam logic [2:0] ADDR_RESUBMIT = {REG_RESUBMIT, 2'b00};
	localparam int         QUIET_LIMIT   = 4000;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// parser state as predicted
	logic [STATE_W-1:0] prs_state;
	logic [COUNT_W-1:0] prs_count;
	logic               prs_bad;
	logic [7:0]         prs_intro;
	logic               cfg_capture;
	logic               cfg_resubmit;
	logic               cap_v;
	logic [7:0]         cap_b;
	logic [INDEX_W-1:0] cap_i;

	res_t awaited_results [$];

	bit idle_on;
	int stall_left;
	int quiet_cycles;
	int mismatches;
	int n_sent;
	int n_in;
	int n_out;
	int n_aborts;
	int n_captured;

	ansi_escape_sequence_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic void open_seq(input logic [7:0] kind);
		prs_count = '0;
		prs_bad   = 1'b0;
		prs_intro = kind;
	endfunction

	function automatic logic take_body(input logic [7:0] b);
		if (prs_bad || prs_count >= BODY_MAX)
			return 1'b0;
		if (cfg_capture) begin
			cap_v = 1'b1;
			cap_b = b;
			cap_i = prs_count[INDEX_W-1:0];
		end
		prs_count = prs_count + COUNT_W'(1);
		return 1'b1;
	endfunction

	function automatic logic [1:0] abort_seq();
		prs_state = ST_GROUND;
		prs_bad   = 1'b1;
		return EV_ABORT;
	endfunction

	function automatic logic [1:0] parse_byte(input logic [7:0] b);
		case (prs_state)
			ST_ESC: begin
				if (b == BYTE_CSI) begin
					prs_state = ST_CSI;
					open_seq(b);
					return EV_SEQ;
				end
				if (b == BYTE_OSC || b == BYTE_DCS || b == BYTE_SOS || b == BYTE_PM ||
				    b == BYTE_APC) begin
					prs_state = ST_STR;
					open_seq(b);
					return EV_SEQ;
				end
				if (b >= 8'h30 && b <= 8'h7E) begin
					prs_state = ST_GROUND;
					prs_intro = b;
					return EV_END;
				end
				if (b >= 8'h20 && b <= 8'h2F) begin
					prs_state = ST_NF;
					open_seq(b);
					return EV_SEQ;
				end
				return abort_seq();
			end
			ST_CSI: begin
				if (b >= 8'h40 && b <= 8'h7E) begin
					if (!take_body(b))
						return abort_seq();
					prs_state = ST_GROUND;
					return EV_END;
				end
				if (b >= 8'h20 && b <= 8'h3F)
					if (take_body(b))
						return EV_SEQ;
				return abort_seq();
			end
			ST_STR: begin
				if (b == BYTE_BEL) begin
					prs_state = ST_GROUND;
					return EV_END;
				end
				if (b == BYTE_ESC) begin
					prs_state = ST_STRESC;
					return EV_SEQ;
				end
				if (b >= 8'h20)
					if (take_body(b))
						return EV_SEQ;
				return abort_seq();
			end
			ST_STRESC: begin
				if (b == BYTE_BSLASH) begin
					prs_state = ST_GROUND;
					return EV_END;
				end
				return abort_seq();
			end
			ST_NF: begin
				if (b >= 8'h30 && b <= 8'h7E) begin
					if (!take_body(b))
						return abort_seq();
					prs_state = ST_GROUND;
					return EV_END;
				end
				if (b >= 8'h20 && b <= 8'h2F)
					if (take_body(b))
						return EV_SEQ;
				return abort_seq();
			end
			default: begin
				prs_state = ST_GROUND;
				if (b == BYTE_ESC) begin
					prs_state = ST_ESC;
					open_seq(8'h00);
					return EV_SEQ;
				end
				return EV_TEXT;
			end
		endcase
	endfunction

	function automatic res_t classify_byte(input logic [7:0] b);
		res_t       r;
		logic [1:0] ev;
		cap_v = 1'b0;
		cap_b = '0;
		cap_i = '0;
		ev = parse_byte(b);
		if (ev == EV_ABORT && cfg_resubmit)
			ev = parse_byte(b);
		r.event_res      = ev;
		r.seq_introducer = prs_intro;
		r.body_length    = prs_count;
		r.string_ok      = cfg_capture && !prs_bad && prs_intro != 8'h00;
		r.captured_valid = cap_v;
		r.captured_byte  = cap_b;
		r.captured_index = cap_i;
		return r;
	endfunction

	task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch in %s of result word %0d: expected 0x%0h, got 0x%0h",
				         what, n_out, want, got);
		end
	endtask

	always @(posedge clk) begin : monitor
		res_t want;
		res_t got;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				want = classify_byte(s_axis_tdata);
				awaited_results.push_back(want);
				n_in++;
				if (want.event_res == EV_ABORT)
					n_aborts++;
				if (want.captured_valid)
					n_captured++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = res_t'(m_axis_tdata[44:0]);
				if (awaited_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result word %0d arrived with none outstanding: 0x%0h",
						         n_out, m_axis_tdata);
				end else begin
					want = awaited_results.pop_front();
					check_field("event_res", 32'(want.event_res), 32'(got.event_res));
					check_field("seq_introducer", 32'(want.seq_introducer),
					            32'(got.seq_introducer));
					check_field("body_length", 32'(want.body_length), 32'(got.body_length));
					check_field("string_ok", 32'(want.string_ok), 32'(got.string_ok));
					check_field("captured_valid", 32'(want.captured_valid),
					            32'(got.captured_valid));
					check_field("captured_byte", 32'(want.captured_byte),
					            32'(got.captured_byte));
					check_field("captured_index", 32'(want.captured_index),
					            32'(got.captured_index));
					check_field("padding", 32'd0, 32'(m_axis_tdata[OUT_TDATA_W-1:45]));
				end
				n_out++;
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			if (stall_left == 0)
				m_axis_tready <= 1'b1;
		end else if (arst_n && idle_on && $urandom_range(0, 11) == 0) begin
			stall_left = $urandom_range(1, 18);
			m_axis_tready <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no word moved for %0d cycles, %0d results outstanding",
			         quiet_cycles, awaited_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (idle_on && $urandom_range(0, 9) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		n_sent++;
	endtask

	task automatic send_seq(input byte_q_t seq);
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic capture, input logic resubmit);
		logic [2:0]  addrs [2];
		logic [31:0] vals  [2];
		addrs[0] = ADDR_CAPTURE;
		addrs[1] = ADDR_RESUBMIT;
		vals[0]  = {31'd0, capture};
		vals[1]  = {31'd0, resubmit};
		drain();
		for (int i = 0; i < 2; i++) begin
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b1;
			paddr   <= addrs[i];
			pwdata  <= vals[i];
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cfg_capture  = capture;
		cfg_resubmit = resubmit;
	endtask

	task automatic test_text_and_single_escapes();
		send_seq({8'h00, 8'hFF, 8'h41});
		send_seq({BYTE_ESC, 8'h63, BYTE_ESC, 8'h37, BYTE_ESC, 8'h7E});
	endtask

	task automatic test_csi_and_nf();
		send_seq({BYTE_ESC, BYTE_CSI, 8'h3F, 8'h32, 8'h6C});
		send_seq({BYTE_ESC, 8'h20, 8'h2F, 8'h30});
	endtask

	task automatic test_string_terminators();
		send_seq({BYTE_ESC, BYTE_OSC, 8'h20, 8'hFF, BYTE_BEL});
		send_seq({BYTE_ESC, BYTE_APC, 8'h80, BYTE_ESC, BYTE_BSLASH});
	endtask

	task automatic test_aborts();
		send_seq({BYTE_ESC, 8'h01, 8'h42, BYTE_ESC, BYTE_CSI, 8'h31, 8'h0A});
		set_config(1'b1, 1'b1);
		send_seq({BYTE_ESC, BYTE_DCS, BYTE_ESC, 8'h41, 8'h42});
		send_seq({BYTE_ESC, BYTE_CSI, BYTE_ESC, BYTE_CSI, 8'h6D});
	endtask

	task automatic build_sequence(output byte_q_t seq);
		int kind;
		seq  = {};
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1: begin
				repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom_range(0, 255)));
			end
			2: seq = {BYTE_ESC, 8'($urandom_range(8'h30, 8'h7E))};
			3, 4: begin
				seq = {BYTE_ESC, BYTE_CSI};
				repeat ($urandom_range(0, 6)) seq.push_back(8'($urandom_range(8'h20, 8'h3F)));
				seq.push_back(8'($urandom_range(8'h40, 8'h7E)));
			end
			5, 6: begin
				case ($urandom_range(0, 4))
					0: seq = {BYTE_ESC, BYTE_OSC};
					1: seq = {BYTE_ESC, BYTE_DCS};
					2: seq = {BYTE_ESC, BYTE_SOS};
					3: seq = {BYTE_ESC, BYTE_PM};
					default: seq = {BYTE_ESC, BYTE_APC};
				endcase
				repeat ($urandom_range(0, 8)) seq.push_back(8'($urandom_range(8'h20, 8'hFF)));
				if ($urandom_range(0, 1))
					seq.push_back(BYTE_BEL);
				else
					seq = {seq, BYTE_ESC, BYTE_BSLASH};
			end
			7: begin
				seq = {BYTE_ESC, 8'($urandom_range(8'h20, 8'h2F))};
				repeat ($urandom_range(0, 3)) seq.push_back(8'($urandom_range(8'h20, 8'h2F)));
				seq.push_back(8'($urandom_range(8'h30, 8'h7E)));
			end
			8: seq = {BYTE_ESC, 8'($urandom_range(0, 255))};
			default: seq = {8'($urandom_range(0, 255))};
		endcase
		// corrupt one byte after the ESC now and then
		if (kind >= 2 && kind <= 7 && $urandom_range(0, 4) == 0)
			seq[$urandom_range(1, seq.size() - 1)] = 8'($urandom_range(0, 255));
	endtask

	task automatic test_random(input int count);
		byte_q_t seq;
		int      stop_at;
		stop_at = n_sent + count;
		while (n_sent < stop_at) begin
			build_sequence(seq);
			send_seq(seq);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b1;
		idle_on       = 1'b1;
		prs_state     = ST_GROUND;
		prs_count     = '0;
		prs_bad       = 1'b0;
		prs_intro     = '0;
		cfg_capture   = 1'b0;
		cfg_resubmit  = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(1'b1, 1'b0);
		test_text_and_single_escapes();
		test_csi_and_nf();
		test_string_terminators();
		test_aborts();

		set_config(1'b0, 1'b0);
		test_random(100);
		set_config(1'b1, 1'b1);
		test_random(100);
		set_config(1'b0, 1'b1);
		test_random(100);
		set_config(1'b1, 1'b0);
		test_random(100);

		idle_on = 1'b0;
		set_config(1'b1, 1'b1);
		test_random(50);

		drain();
		repeat (8) @(posedge clk);
		if (awaited_results.size() != 0) begin
			mismatches++;
			$display("%0d result words never arrived", awaited_results.size());
		end

		$display("%0d bytes in, %0d result words checked, %0d aborts, %0d captured body bytes",
		         n_in, n_out, n_aborts, n_captured);
		$display("text, single escapes, CSI, nF and strings under every register setting, %0d mismatches",
		         mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
